FILE: rtl/label_boundary_classifier_3x3_unit_assert.svh
// Assertion macros for the label boundary classifier.
`ifndef LABEL_BOUNDARY_CLASSIFIER_3X3_UNIT_ASSERT_SVH
`define LABEL_BOUNDARY_CLASSIFIER_3X3_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define LBC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lbc assertion failed");
`define LBC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lbc assertion failed");
`else
`define LBC_ASSERT(name, clk, rst, prop)
`define LBC_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

FILE: rtl/lbc_pkg.sv
package lbc_pkg;

  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_WIDTH  = 1024;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 11;
  localparam int LABEL_W    = 2;
  localparam int WIN_W      = 9 * LABEL_W;
  localparam int ENTRY_W    = 2 * LABEL_W;

  typedef enum logic [0:0] {
    REG_IMAGE_HEIGHT = 1'b0,
    REG_IMAGE_WIDTH  = 1'b1
  } cfg_reg_t;

  localparam logic [LABEL_W-1:0] LBL_ZERO = 2'd0;
  localparam logic [LABEL_W-1:0] LBL_ONE  = 2'd1;
  localparam logic [LABEL_W-1:0] LBL_TWO  = 2'd2;

  localparam logic [1:0] CLASS_NONE    = 2'd0;
  localparam logic [1:0] CLASS_INNER   = 2'd1;
  localparam logic [1:0] CLASS_TOUCH_0 = 2'd2;
  localparam logic [1:0] CLASS_TOUCH_1 = 2'd3;

  // position and flags of one incoming pixel
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             emit;
    logic             last;
  } pos_t;

  function automatic logic [1:0] classify(input logic [WIN_W-1:0] w);
    logic any0;
    logic any1;
    logic all2;
    logic [LABEL_W-1:0] v;
    any0 = 1'b0;
    any1 = 1'b0;
    all2 = 1'b1;
    for (int i = 0; i < 9; i++) begin
      v = w[LABEL_W*i +: LABEL_W];
      if (i != 4) begin
        if (v == LBL_ZERO) any0 = 1'b1;
        if (v == LBL_ONE) any1 = 1'b1;
        if (v != LBL_TWO) all2 = 1'b0;
      end
    end
    if (w[LABEL_W*4 +: LABEL_W] != LBL_TWO) return CLASS_NONE;
    if (any1) return CLASS_TOUCH_1;
    if (any0) return CLASS_TOUCH_0;
    if (all2) return CLASS_INNER;
    return CLASS_NONE;
  endfunction

endpackage

FILE: rtl/lbc_line_store.sv
module lbc_line_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [lbc_pkg::ROW_W-1:0]    rd_addr,
  input  logic                         wr_en,
  input  logic [lbc_pkg::ROW_W-1:0]    wr_addr,
  input  logic [lbc_pkg::ENTRY_W-1:0]  wr_data,
  output logic [lbc_pkg::ENTRY_W-1:0]  rd_data
);
  import lbc_pkg::*;

  // entry = {column c-1, column c-2}
  logic [ENTRY_W-1:0] mem [MAX_HEIGHT];
  logic [ENTRY_W-1:0] rd_q;
  logic [ENTRY_W-1:0] fwd_data;
  logic               fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // read and write of the same entry at one edge: take the new data
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule

FILE: rtl/lbc_scan_ctrl.sv
`include "label_boundary_classifier_3x3_unit_assert.svh"

module lbc_scan_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [0:0]                cfg_index,
  input  logic [lbc_pkg::DIM_W-1:0] cfg_data,
  input  logic                      accept,
  output lbc_pkg::pos_t             pos
);
  import lbc_pkg::*;

  logic [DIM_W-1:0] image_height;
  logic [DIM_W-1:0] image_width;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] h_last;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] col_next;
  logic             row_wrap;
  logic             col_wrap;

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    priority if (image_height == '0) begin
      h_last = '0;
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      h_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(image_height - 1'b1);
    end
    priority if (image_width == '0) begin
      w_last = '0;
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(image_width - 1'b1);
    end
  end

  assign row_wrap = (row_count == h_last);
  assign col_wrap = (col_count == w_last);

  always_comb begin
    row_next = row_wrap ? '0 : row_count + 1'b1;
    col_next = col_count;
    if (row_wrap) begin
      col_next = col_wrap ? '0 : col_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= DIM_W'(MAX_HEIGHT);
      image_width  <= DIM_W'(MAX_WIDTH);
      row_count    <= '0;
      col_count    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        default:          image_height <= image_height;
      endcase
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_next;
      col_count <= col_next;
    end
  end

  assign pos.row  = row_count;
  assign pos.col  = col_count;
  assign pos.emit = (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));
  assign pos.last = row_wrap && col_wrap;

  `LBC_ASSERT(a_row_in_range, clk, rst, row_count <= h_last)
  `LBC_ASSERT(a_col_in_range, clk, rst, col_count <= w_last)
  `LBC_ASSERT(a_cfg_restarts, clk, rst, cfg_wr_en |=> (row_count == '0 && col_count == '0))

endmodule

FILE: rtl/label_boundary_classifier_3x3_unit.sv
// Label boundary classifier, 3x3 neighborhood.
// Input channel: one label per request, column-major (row index runs fastest),
// in_valid/in_stall handshake. Output channel: one request per interior pixel
// carrying pixel_class, out_row, out_col and frame_end (set on the last interior
// result of a frame); border pixels produce nothing.
// Config port: cfg_wr_en/cfg_index/cfg_data writes image_height (index 0) or
// image_width (index 1); any write restarts the frame at row 0, column 0.
// Throughput: one label per cycle sustained while the output is not stalled.
// The line store read is registered when the label is accepted, and the
// window update and classification load the output register when the read
// stage advances, which an output stall can hold off.
// The two previous columns live in a 1024 x 4-bit line store with one read and
// one write port; a read that meets a write to the same row is forwarded.
// Reset: dimensions return to 1024 x 1024, counters and window clear; the line
// store is not cleared, as every result only uses rows written in that frame.
// Output stall: the result stays in the output register; one more label is taken
// into the read stage, after which in_stall rises until the output drains.
`include "label_boundary_classifier_3x3_unit_assert.svh"

module label_boundary_classifier_3x3_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [0:0]                  cfg_index,
  input  logic [lbc_pkg::DIM_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lbc_pkg::LABEL_W-1:0] label,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  pixel_class,
  output logic [9:0]                  out_row,
  output logic [9:0]                  out_col,
  output logic                        frame_end
);
  import lbc_pkg::*;

  pos_t               pos;
  logic               accept;
  logic               s1_valid;
  logic [LABEL_W-1:0] s1_label;
  pos_t               s1_pos;
  logic               advance;
  logic [ENTRY_W-1:0] rd_data;
  logic [LABEL_W-1:0] p1;
  logic [LABEL_W-1:0] p2;
  logic [WIN_W-1:0]   window_regs;
  logic [WIN_W-1:0]   window_next;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  lbc_scan_ctrl u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .pos       (pos)
  );

  lbc_line_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (pos.row),
    .wr_en   (advance),
    .wr_addr (s1_pos.row),
    .wr_data ({s1_label, p1}),
    .rd_data (rd_data)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_label <= label;
      s1_pos   <= pos;
    end
  end

  assign p1 = rd_data[ENTRY_W-1:LABEL_W];
  assign p2 = rd_data[LABEL_W-1:0];
  // newest row of the window enters at the top bits
  assign window_next = {s1_label, p1, p2, window_regs[WIN_W-1:3*LABEL_W]};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_regs <= '0;
    end else if (advance) begin
      window_regs <= window_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_pos.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_pos.emit) begin
      pixel_class <= classify(window_next);
      out_row     <= 10'(s1_pos.row - 1'b1);
      out_col     <= 10'(s1_pos.col - 1'b1);
      frame_end   <= s1_pos.last;
    end
  end

  `LBC_ASSERT(a_stall_needs_item, clk, rst, in_stall |-> s1_valid)
  `LBC_ASSERT(a_item_held, clk, rst, (s1_valid && !advance) |=> s1_valid)
  `LBC_ASSERT(a_stall_on_full_out, clk, rst, in_stall |-> (out_valid && out_stall))
  `LBC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!out_valid && !s1_valid))

endmodule

FILE: test/tb_label_boundary_classifier_3x3_unit.sv
`timescale 1ns / 100ps

module tb_label_boundary_classifier_3x3_unit;
  import lbc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  // results trail their labels through the read stage and output register; leave margin before a register write
  localparam int SETTLE_CYCLES = 6;
  localparam logic [LABEL_W-1:0] LBL_OTHER = 2'd3;

  typedef struct packed {
    logic [1:0] pixel_class;
    logic [9:0] row;
    logic [9:0] col;
    logic       frame_end;
  } pixel_result_t;

  class boundary_scoreboard;
    logic [LABEL_W-1:0] col_prev [MAX_HEIGHT];
    logic [LABEL_W-1:0] col_prev2 [MAX_HEIGHT];
    logic [WIN_W-1:0] window;
    int unsigned row_cnt;
    int unsigned col_cnt;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
    pixel_result_t pending_results[$];
    int errors;

    function new();
      foreach (col_prev[i]) begin
        col_prev[i] = '0;
        col_prev2[i] = '0;
      end
      window = '0;
      row_cnt = 0;
      col_cnt = 0;
      height = 11'd1024;
      width = 11'd1024;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [DIM_W-1:0] v);
      if (idx == REG_IMAGE_HEIGHT) height = v;
      else width = v;
      // any write restarts the frame; line stores and window are kept
      row_cnt = 0;
      col_cnt = 0;
    endfunction

    static function int unsigned limit_dim(logic [DIM_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    static function logic [1:0] classify_window(logic [WIN_W-1:0] win);
      logic touch0;
      logic touch1;
      logic ring2;
      logic [LABEL_W-1:0] v;
      touch0 = 1'b0;
      touch1 = 1'b0;
      ring2 = 1'b1;
      if (win[4*LABEL_W +: LABEL_W] != LBL_TWO) return CLASS_NONE;
      for (int i = 0; i < 9; i++) begin
        if (i != 4) begin
          v = win[i*LABEL_W +: LABEL_W];
          if (v == LBL_ZERO) touch0 = 1'b1;
          if (v == LBL_ONE) touch1 = 1'b1;
          if (v != LBL_TWO) ring2 = 1'b0;
        end
      end
      if (touch1) return CLASS_TOUCH_1;
      if (touch0) return CLASS_TOUCH_0;
      if (ring2) return CLASS_INNER;
      return CLASS_NONE;
    endfunction

    function void note_label(logic [LABEL_W-1:0] lab);
      int unsigned h;
      int unsigned w;
      logic [LABEL_W-1:0] p1;
      logic [LABEL_W-1:0] p2;
      pixel_result_t res;
      h = limit_dim(height, MAX_HEIGHT);
      w = limit_dim(width, MAX_WIDTH);
      p2 = col_prev2[row_cnt];
      p1 = col_prev[row_cnt];
      // newest row slot on top, oldest shifted out at the bottom
      window = {lab, p1, p2, window[WIN_W-1:3*LABEL_W]};
      col_prev2[row_cnt] = p1;
      col_prev[row_cnt] = lab;
      if (row_cnt >= 2 && col_cnt >= 2) begin
        res.pixel_class = classify_window(window);
        res.row = 10'(row_cnt - 1);
        res.col = 10'(col_cnt - 1);
        res.frame_end = (row_cnt == h - 1) && (col_cnt == w - 1);
        pending_results.push_back(res);
      end
      row_cnt++;
      if (row_cnt >= h) begin
        row_cnt = 0;
        col_cnt++;
        if (col_cnt >= w) col_cnt = 0;
      end
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result class=%0d row=%0d col=%0d frame_end=%0d",
                 $time, got.pixel_class, got.row, got.col, got.frame_end);
        return;
      end
      want = pending_results.pop_front();
      if (got.pixel_class !== want.pixel_class) begin
        errors++;
        $display("%0t: pixel_class expected %0d actual %0d (row %0d col %0d)",
                 $time, want.pixel_class, got.pixel_class, want.row, want.col);
      end
      if (got.row !== want.row) begin
        errors++;
        $display("%0t: out_row expected %0d actual %0d", $time, want.row, got.row);
      end
      if (got.col !== want.col) begin
        errors++;
        $display("%0t: out_col expected %0d actual %0d", $time, want.col, got.col);
      end
      if (got.frame_end !== want.frame_end) begin
        errors++;
        $display("%0t: frame_end expected %0d actual %0d (row %0d col %0d)",
                 $time, want.frame_end, got.frame_end, want.row, want.col);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [LABEL_W-1:0] label = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] pixel_class;
  logic [9:0] out_row;
  logic [9:0] out_col;
  logic frame_end;

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int cycle_cnt = 0;
  boundary_scoreboard sb = new();

  label_boundary_classifier_3x3_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .label(label),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_class(pixel_class),
    .out_row(out_row),
    .out_col(out_col),
    .frame_end(frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (rcv_idle_pct != 0) && ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0)
      sb.check_result(pixel_result_t'({pixel_class, out_row, out_col, frame_end}));
  end

  task automatic write_reg(cfg_reg_t idx, logic [DIM_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_label(logic [LABEL_W-1:0] lab);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    label <= lab;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_label(lab);
  endtask

  // hold off requests until every expected result is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [DIM_W-1:0] h, logic [DIM_W-1:0] w, int n,
                           int two_pct, bit pause_mid);
    drain();
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_IMAGE_WIDTH, w);
    for (int k = 0; k < n; k++) begin
      if (pause_mid && k == n / 2) drain();
      // bias toward label 2 so inner and boundary windows show up
      if ($urandom_range(99) < two_pct) send_label(LBL_TWO);
      else send_label(LABEL_W'($urandom_range(3)));
    end
  endtask

  // 3x7 frame, column by column: inner, mixed with other label, touches 0,
  // touches 1 and 0, non-2 center; then a few labels into the next frame
  localparam logic [LABEL_W-1:0] DIRECTED_LABELS [25] = '{
    LBL_TWO, LBL_TWO, LBL_TWO,
    LBL_TWO, LBL_TWO, LBL_TWO,
    LBL_TWO, LBL_TWO, LBL_TWO,
    LBL_TWO, LBL_TWO, LBL_OTHER,
    LBL_ZERO, LBL_TWO, LBL_TWO,
    LBL_TWO, LBL_ONE, LBL_ZERO,
    LBL_TWO, LBL_TWO, LBL_TWO,
    LBL_OTHER, LBL_OTHER, LBL_OTHER, LBL_ZERO
  };

  initial begin
    int two_pcts [3];
    two_pcts = '{50, 80, 95};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle_pct = 6;
    rcv_idle_pct = 56;
    write_reg(REG_IMAGE_HEIGHT, 11'd3);
    write_reg(REG_IMAGE_WIDTH, 11'd7);
    foreach (DIRECTED_LABELS[i]) send_label(DIRECTED_LABELS[i]);

    run_phase(11'd2, 11'd5, 30, 50, 1'b0);
    run_phase(11'd0, 11'd2047, 40, 50, 1'b0);
    run_phase(11'd4, 11'd5, 70, 80, 1'b1);
    run_phase(11'd2047, 11'd3, 300, 70, 1'b0);

    drain();
    snd_idle_pct = 56;
    rcv_idle_pct = 6;
    run_phase(11'd3, 11'd2047, 600, 70, 1'b0);
    run_phase(11'd7, 11'd1, 40, 50, 1'b0);
    run_phase(11'd5, 11'd6, 95, 95, 1'b0);
    run_phase(11'd1024, 11'd0, 30, 50, 1'b0);

    drain();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    repeat (6)
      run_phase(DIM_W'($urandom_range(3, 12)), DIM_W'($urandom_range(3, 12)),
                $urandom_range(40, 160), two_pcts[$urandom_range(2)], 1'b0);
    run_phase(11'd3, 11'd3, 20, 90, 1'b0);

    drain();
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lbc_pkg.sv
rtl/lbc_line_store.sv
rtl/lbc_scan_ctrl.sv
rtl/label_boundary_classifier_3x3_unit.sv
test/tb_label_boundary_classifier_3x3_unit.sv
